// ----- src/tcit_pkg.sv -----
`timescale 1ns / 1ps

package tcit_pkg;

    localparam int NUM_COUNTERS_DEF = 3;
    localparam int MAX_TICKS_DEF    = 16;

    localparam int CNT_W  = 17;
    localparam int WV_W   = 19;
    localparam int IDX_W  = 2;

    localparam logic [16:0] WRAP_BIN = 17'h10000;
    localparam logic [16:0] WRAP_BCD = 17'd10000;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [1:0] ADDR_CTRL  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV_START,
        S_ADV_LOOP,
        S_ADV_STORE,
        S_CTRL,
        S_WRITE,
        S_RD_START,
        S_RD_STEP,
        S_RD_DONE,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLR,
        CMD_ADV_START,
        CMD_ADV_STEP,
        CMD_ADV_STORE,
        CMD_CTRL,
        CMD_WRITE,
        CMD_RD_START,
        CMD_RD_STEP,
        CMD_RD_DONE,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [IDX_W-1:0]  idx;
        logic [4:0]        n;
        logic [7:0]        wdata;
    } dp_cmd_t;

    typedef struct packed {
        logic adv_loop;
        logic wv_pos;
    } dp_sts_t;

endpackage

// ----- src/tcit_ctrl.sv -----
`timescale 1ns / 1ps

module tcit_ctrl #(
    parameter int NUM_COUNTERS = tcit_pkg::NUM_COUNTERS_DEF,
    parameter int MAX_TICKS    = tcit_pkg::MAX_TICKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [1:0]        kind,
    input  logic [1:0]        addr,
    input  logic [7:0]        write_data,
    input  logic [4:0]        tick_count,
    output logic              result_valid,
    input  logic              result_ready,
    output tcit_pkg::dp_cmd_t cmd,
    input  tcit_pkg::dp_sts_t sts
);

    tcit_pkg::state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic [4:0] n_reg, n_next;
    logic [tcit_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [1:0] dig_reg, dig_next;
    logic       ovalid_reg, ovalid_next;
    logic [4:0] tick_sat;
    logic       last_cnt;

    assign item_ready   = (state_reg == tcit_pkg::S_IDLE);
    assign result_valid = ovalid_reg;
    assign tick_sat     = ({2'b00, tick_count} > 7'(MAX_TICKS)) ? 5'(MAX_TICKS) : tick_count;
    assign last_cnt     = (32'(idx_reg) + 32'd1 >= 32'(NUM_COUNTERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tcit_pkg::S_IDLE;
            kind_reg   <= '0;
            data_reg   <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            dig_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            dig_reg    <= dig_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        data_next   = data_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        dig_next    = dig_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && result_ready)
        begin
            ovalid_next = 1'b0;
        end
        cmd.op    = tcit_pkg::CMD_NONE;
        cmd.idx   = idx_reg;
        cmd.n     = n_reg;
        cmd.wdata = data_reg;

        unique case (state_reg)
            tcit_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = tcit_pkg::CMD_CLR;
                    kind_next  = kind;
                    data_next  = write_data;
                    state_next = tcit_pkg::S_FINISH;
                    if (kind == tcit_pkg::KIND_WRITE)
                    begin
                        if (addr == tcit_pkg::ADDR_CTRL)
                        begin
                            if (32'(write_data[7:6]) < NUM_COUNTERS)
                            begin
                                idx_next   = write_data[7:6];
                                n_next     = 5'd1;
                                state_next = tcit_pkg::S_ADV_START;
                            end
                        end
                        else if (32'(addr) < NUM_COUNTERS)
                        begin
                            idx_next   = addr;
                            state_next = tcit_pkg::S_WRITE;
                        end
                    end
                    else if (kind == tcit_pkg::KIND_READ)
                    begin
                        if (addr != tcit_pkg::ADDR_CTRL && 32'(addr) < NUM_COUNTERS)
                        begin
                            idx_next   = addr;
                            state_next = tcit_pkg::S_RD_START;
                        end
                    end
                    else if (kind == tcit_pkg::KIND_TICK && tick_count != 5'd0)
                    begin
                        idx_next   = '0;
                        n_next     = tick_sat;
                        state_next = tcit_pkg::S_ADV_START;
                    end
                end
            end
            tcit_pkg::S_ADV_START:
            begin
                cmd.op = tcit_pkg::CMD_ADV_START;
                if (sts.adv_loop)
                begin
                    state_next = tcit_pkg::S_ADV_LOOP;
                end
                else if (kind_reg == tcit_pkg::KIND_WRITE)
                begin
                    state_next = tcit_pkg::S_CTRL;
                end
                else if (last_cnt)
                begin
                    state_next = tcit_pkg::S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = tcit_pkg::S_ADV_START;
                end
            end
            tcit_pkg::S_ADV_LOOP:
            begin
                if (sts.wv_pos)
                begin
                    state_next = tcit_pkg::S_ADV_STORE;
                end
                else
                begin
                    cmd.op = tcit_pkg::CMD_ADV_STEP;
                end
            end
            tcit_pkg::S_ADV_STORE:
            begin
                cmd.op = tcit_pkg::CMD_ADV_STORE;
                if (kind_reg == tcit_pkg::KIND_WRITE)
                begin
                    state_next = tcit_pkg::S_CTRL;
                end
                else if (last_cnt)
                begin
                    state_next = tcit_pkg::S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = tcit_pkg::S_ADV_START;
                end
            end
            tcit_pkg::S_CTRL:
            begin
                cmd.op     = tcit_pkg::CMD_CTRL;
                state_next = tcit_pkg::S_FINISH;
            end
            tcit_pkg::S_WRITE:
            begin
                cmd.op     = tcit_pkg::CMD_WRITE;
                state_next = tcit_pkg::S_FINISH;
            end
            tcit_pkg::S_RD_START:
            begin
                cmd.op     = tcit_pkg::CMD_RD_START;
                dig_next   = '0;
                state_next = tcit_pkg::S_RD_STEP;
            end
            tcit_pkg::S_RD_STEP:
            begin
                cmd.op   = tcit_pkg::CMD_RD_STEP;
                dig_next = dig_reg + 1'b1;
                if (dig_reg == 2'd3)
                begin
                    state_next = tcit_pkg::S_RD_DONE;
                end
            end
            tcit_pkg::S_RD_DONE:
            begin
                cmd.op     = tcit_pkg::CMD_RD_DONE;
                state_next = tcit_pkg::S_FINISH;
            end
            tcit_pkg::S_FINISH:
            begin
                if (!ovalid_reg || result_ready)
                begin
                    cmd.op      = tcit_pkg::CMD_EMIT;
                    ovalid_next = 1'b1;
                    state_next  = tcit_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcit_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tcit_dp.sv -----
`timescale 1ns / 1ps

module tcit_dp #(
    parameter int NUM_COUNTERS = tcit_pkg::NUM_COUNTERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcit_pkg::dp_cmd_t cmd,
    output tcit_pkg::dp_sts_t sts,
    output logic [7:0]        read_data,
    output logic              out_zero,
    output logic              out_one,
    output logic              out_two
);

    localparam int IW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

    logic [16:0] count_reg    [NUM_COUNTERS];
    logic [16:0] reload_reg   [NUM_COUNTERS];
    logic [16:0] latched_reg  [NUM_COUNTERS];
    logic        held_reg     [NUM_COUNTERS];
    logic        toggle_reg   [NUM_COUNTERS];
    logic [1:0]  access_reg   [NUM_COUNTERS];
    logic [1:0]  mode_reg     [NUM_COUNTERS];
    logic        bcd_reg      [NUM_COUNTERS];
    logic        level_reg    [NUM_COUNTERS];
    logic        armed_reg    [NUM_COUNTERS];
    logic        pending_reg  [NUM_COUNTERS];
    logic [1:0]  phase_reg    [NUM_COUNTERS];
    logic [7:0]  lowhold_reg  [NUM_COUNTERS];

    logic signed [tcit_pkg::WV_W-1:0] wv_reg;
    logic [16:0] wr_reg;
    logic [15:0] x_reg;
    logic [15:0] digits_reg;
    logic [7:0]  rd_reg;
    logic [7:0]  rd_out_reg;
    logic [2:0]  lvl_out_reg;
    logic [2:0]  lvl_vec;

    logic [IW-1:0] c;
    logic          act, doload;
    logic [16:0]   v0, rr, wrap_add;
    logic [5:0]    n2;
    logic signed [tcit_pkg::WV_W-1:0] vsub, v_wrap, step_add;
    logic          m0_level, m0_armed;
    logic          lvl_new;
    logic [1:0]    odd_sub;
    logic [31:0]   prod;
    logic [12:0]   q;
    logic [15:0]   rem;
    logic [15:0]   rd_val;
    logic [15:0]   ld_raw;
    logic [16:0]   ld_bin, ld_fin;
    logic          ld_done;

    function automatic logic [16:0] bcd_to_bin(input logic [15:0] x);
        logic [3:0] d3, d2, d1, d0;
        d3 = (x[15:12] > 4'd9) ? 4'd9 : x[15:12];
        d2 = (x[11:8]  > 4'd9) ? 4'd9 : x[11:8];
        d1 = (x[7:4]   > 4'd9) ? 4'd9 : x[7:4];
        d0 = (x[3:0]   > 4'd9) ? 4'd9 : x[3:0];
        return 17'(d3) * 17'd1000 + 17'(d2) * 17'd100 + 17'(d1) * 17'd10 + 17'(d0);
    endfunction

    assign c = cmd.idx[IW-1:0];

    // advance: outside mode 1, load on first clock after a completed write, then count down
    always_comb
    begin
        doload   = (phase_reg[c] == 2'd1) && pending_reg[c];
        act      = (phase_reg[c] == 2'd2) || doload;
        v0       = (doload && mode_reg[c] != 2'd1) ? reload_reg[c] : count_reg[c];
        n2       = (mode_reg[c] == 2'd3) ? {cmd.n, 1'b0} : {1'b0, cmd.n};
        vsub     = $signed({2'b00, v0}) - $signed({13'b0, n2});
        wrap_add = bcd_reg[c] ? tcit_pkg::WRAP_BCD : tcit_pkg::WRAP_BIN;
        v_wrap   = vsub;
        m0_armed = doload ? 1'b1 : armed_reg[c];
        m0_level = doload ? 1'b0 : level_reg[c];
        if (vsub <= 0)
        begin
            v_wrap = vsub + $signed({2'b00, wrap_add});
            if (m0_armed)
            begin
                if (v0 != 17'd0)
                begin
                    m0_level = 1'b1;
                end
                m0_armed = 1'b0;
            end
        end
        rr = reload_reg[c];
        if (mode_reg[c] == 2'd3)
        begin
            if (rr < 17'd2)
            begin
                rr = 17'd2;
            end
        end
        else if (rr == 17'd0)
        begin
            rr = 17'd1;
        end
        // square wave step: odd reload trims 1 or 3 depending on new level
        lvl_new  = ~level_reg[c];
        odd_sub  = wr_reg[0] ? (lvl_new ? 2'd1 : 2'd3) : 2'd0;
        step_add = (mode_reg[c] == 2'd3)
                 ? $signed({2'b00, wr_reg - {15'b0, odd_sub}})
                 : $signed({2'b00, wr_reg});
    end

    assign sts.adv_loop = act && (mode_reg[c] != 2'd0);
    assign sts.wv_pos   = !wv_reg[tcit_pkg::WV_W-1] && (wv_reg != '0);

    // BCD digit extraction, one digit per step
    assign prod = 32'(x_reg) * 32'h0000_CCCD;
    assign q    = prod[31:19];
    assign rem  = x_reg - {q, 3'b000} - {2'b00, q, 1'b0};

    assign rd_val = bcd_reg[c] ? digits_reg
                  : (held_reg[c] ? latched_reg[c][15:0] : count_reg[c][15:0]);

    always_comb
    begin
        ld_raw  = '0;
        ld_done = 1'b0;
        unique case (access_reg[c])
            2'd1:
            begin
                ld_raw  = {8'h00, cmd.wdata};
                ld_done = 1'b1;
            end
            2'd2:
            begin
                ld_raw  = {cmd.wdata, 8'h00};
                ld_done = 1'b1;
            end
            2'd3:
            begin
                ld_raw  = {cmd.wdata, lowhold_reg[c]};
                ld_done = toggle_reg[c];
            end
            default:
            begin
                ld_done = 1'b0;
            end
        endcase
        ld_bin = bcd_reg[c] ? bcd_to_bin(ld_raw) : {1'b0, ld_raw};
        ld_fin = ld_bin;
        if (mode_reg[c] == 2'd1)
        begin
            ld_fin = (ld_bin == 17'd0) ? wrap_add : ld_bin + 17'd1;
        end
        else if (mode_reg[c] != 2'd0 && ld_bin == 17'd0)
        begin
            ld_fin = wrap_add;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lvl
            if (g < NUM_COUNTERS)
            begin : g_on
                assign lvl_vec[g] = level_reg[g];
            end
            else
            begin : g_off
                assign lvl_vec[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                count_reg[i]   <= '0;
                reload_reg[i]  <= '0;
                latched_reg[i] <= '0;
                held_reg[i]    <= 1'b0;
                toggle_reg[i]  <= 1'b0;
                access_reg[i]  <= '0;
                mode_reg[i]    <= '0;
                bcd_reg[i]     <= 1'b0;
                level_reg[i]   <= 1'b0;
                armed_reg[i]   <= 1'b0;
                pending_reg[i] <= 1'b0;
                phase_reg[i]   <= '0;
                lowhold_reg[i] <= '0;
            end
            wv_reg      <= '0;
            wr_reg      <= '0;
            x_reg       <= '0;
            digits_reg  <= '0;
            rd_reg      <= '0;
            rd_out_reg  <= '0;
            lvl_out_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                tcit_pkg::CMD_CLR:
                begin
                    rd_reg <= '0;
                end
                tcit_pkg::CMD_ADV_START:
                begin
                    if (act)
                    begin
                        if (doload)
                        begin
                            pending_reg[c] <= 1'b0;
                            phase_reg[c]   <= 2'd2;
                        end
                        if (mode_reg[c] == 2'd0)
                        begin
                            count_reg[c] <= v_wrap[16:0];
                            level_reg[c] <= m0_level;
                            armed_reg[c] <= m0_armed;
                        end
                        wv_reg <= vsub;
                        wr_reg <= rr;
                    end
                end
                tcit_pkg::CMD_ADV_STEP:
                begin
                    wv_reg <= wv_reg + step_add;
                    if (mode_reg[c] == 2'd3)
                    begin
                        level_reg[c] <= lvl_new;
                    end
                end
                tcit_pkg::CMD_ADV_STORE:
                begin
                    count_reg[c] <= wv_reg[16:0];
                end
                tcit_pkg::CMD_CTRL:
                begin
                    if (cmd.wdata[5:4] == 2'd0)
                    begin
                        latched_reg[c] <= count_reg[c];
                        held_reg[c]    <= 1'b1;
                    end
                    else
                    begin
                        bcd_reg[c]     <= cmd.wdata[0];
                        mode_reg[c]    <= cmd.wdata[2:1];
                        level_reg[c]   <= (cmd.wdata[2:1] != 2'd0);
                        if (cmd.wdata[2] == 1'b0)
                        begin
                            armed_reg[c] <= 1'b1;
                        end
                        phase_reg[c]   <= 2'd1;
                        pending_reg[c] <= 1'b0;
                        access_reg[c]  <= cmd.wdata[5:4];
                        toggle_reg[c]  <= 1'b0;
                    end
                end
                tcit_pkg::CMD_WRITE:
                begin
                    if (access_reg[c] == 2'd2)
                    begin
                        count_reg[c] <= {1'b0, ld_raw};
                    end
                    if (access_reg[c] == 2'd3)
                    begin
                        toggle_reg[c] <= ~toggle_reg[c];
                        if (!toggle_reg[c])
                        begin
                            lowhold_reg[c] <= cmd.wdata;
                        end
                    end
                    if (ld_done)
                    begin
                        pending_reg[c] <= 1'b1;
                        reload_reg[c]  <= ld_fin;
                    end
                end
                tcit_pkg::CMD_RD_START:
                begin
                    x_reg      <= held_reg[c] ? latched_reg[c][15:0] : count_reg[c][15:0];
                    digits_reg <= '0;
                end
                tcit_pkg::CMD_RD_STEP:
                begin
                    x_reg      <= {3'b000, q};
                    digits_reg <= {rem[3:0], digits_reg[15:4]};
                end
                tcit_pkg::CMD_RD_DONE:
                begin
                    unique case (access_reg[c])
                        2'd1:
                        begin
                            rd_reg      <= rd_val[7:0];
                            held_reg[c] <= 1'b0;
                        end
                        2'd2:
                        begin
                            rd_reg      <= rd_val[15:8];
                            held_reg[c] <= 1'b0;
                        end
                        2'd3:
                        begin
                            toggle_reg[c] <= ~toggle_reg[c];
                            if (!toggle_reg[c])
                            begin
                                rd_reg <= rd_val[7:0];
                            end
                            else
                            begin
                                rd_reg      <= rd_val[15:8];
                                held_reg[c] <= 1'b0;
                            end
                        end
                        default:
                        begin
                            rd_reg <= '0;
                        end
                    endcase
                end
                tcit_pkg::CMD_EMIT:
                begin
                    rd_out_reg  <= rd_reg;
                    lvl_out_reg <= lvl_vec;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign read_data = rd_out_reg;
    assign out_zero  = lvl_out_reg[0];
    assign out_one   = lvl_out_reg[1];
    assign out_two   = lvl_out_reg[2];

endmodule

// ----- src/three_channel_interval_timer_unit.sv -----
`timescale 1ns / 1ps
// Sequencing: a counter write runs S_WRITE; a read, S_RD_START, digit steps, S_RD_DONE;
//   a control word advances its counter, then S_CTRL; a tick batch advances each counter
//   in turn, adding reload loop steps in modes 1-3. Throughput: one transfer in flight;
//   the reload loop and the BCD digit unit (one digit per cycle) set its length.
// Reset: rst_n async low clears all counter state; no clearing pass.
module three_channel_interval_timer_unit #(
    parameter int NUM_COUNTERS = tcit_pkg::NUM_COUNTERS_DEF,
    parameter int MAX_TICKS    = tcit_pkg::MAX_TICKS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] kind,
    input  logic [1:0] addr,
    input  logic [7:0] write_data,
    input  logic [4:0] tick_count,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_data,
    output logic       out_zero,
    output logic       out_one,
    output logic       out_two
);

    // controller sequences counters and steps; datapath holds all counter state
    tcit_pkg::dp_cmd_t cmd;
    tcit_pkg::dp_sts_t sts;

    tcit_ctrl #(
        .NUM_COUNTERS(NUM_COUNTERS),
        .MAX_TICKS(MAX_TICKS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .kind(kind),
        .addr(addr),
        .write_data(write_data),
        .tick_count(tick_count),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .cmd(cmd),
        .sts(sts)
    );

    // result register lets the next transfer start while one waits
    tcit_dp #(
        .NUM_COUNTERS(NUM_COUNTERS)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sts(sts),
        .read_data(read_data),
        .out_zero(out_zero),
        .out_one(out_one),
        .out_two(out_two)
    );

    // busy after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("accepted while busy");

    // reload loop steps only while the working count is not positive
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tcit_pkg::CMD_ADV_STEP) |-> !sts.wv_pos)
        else $error("loop step with positive count");

endmodule

// ----- bench/timer_checker.sv -----
`timescale 1ns / 1ps

module timer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  logic [1:0] kind,
    input  logic [1:0] addr,
    input  logic [7:0] write_data,
    input  logic [4:0] tick_count,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic [7:0] read_data,
    input  logic       out_zero,
    input  logic       out_one,
    input  logic       out_two,
    output int         fail_count,
    output int         pending,
    output int         transfers
);

    localparam int NC = tcit_pkg::NUM_COUNTERS_DEF;

    typedef struct packed {
        logic [7:0] rd;
        logic [2:0] outs;
    } timer_result_t;

    // per-counter timer state
    int unsigned cnt[NC];
    int unsigned rld[NC];
    int unsigned lat[NC];
    bit          lat_held[NC];
    bit          tog[NC];
    bit [1:0]    acc[NC];
    bit [1:0]    md[NC];
    bit          bcd[NC];
    bit          lvl[NC];
    bit          armed[NC];
    bit          ld_pend[NC];
    bit [1:0]    phase[NC];
    bit [7:0]    lo_hold[NC];

    timer_result_t result_q[$];

    function automatic int unsigned to_bcd(int unsigned x);
        int unsigned r;
        r = 0;
        x = x & 16'hffff;
        for (int i = 0; i < 4; i++)
        begin
            r = r | ((x % 10) << (4 * i));
            x = x / 10;
        end
        return r;
    endfunction

    function automatic int unsigned from_bcd(int unsigned x);
        int unsigned r;
        int unsigned d;
        r = 0;
        for (int i = 0; i < 4; i++)
        begin
            d = (x >> (12 - 4 * i)) & 4'hf;
            if (d > 9) d = 9;
            r = r * 10 + d;
        end
        return r;
    endfunction

    task automatic clock_counter(int c, int n);
        int v;
        int r;
        int prev;
        if (phase[c] == 1)
        begin
            if (!ld_pend[c]) return;
            if (md[c] == 0)
            begin
                cnt[c] = rld[c];
                armed[c] = 1;
                lvl[c] = 0;
            end
            else if (md[c] != 1)
            begin
                cnt[c] = rld[c];
            end
            ld_pend[c] = 0;
            phase[c] = 2;
        end
        if (phase[c] != 2) return;
        v = int'(cnt[c]);
        r = int'(rld[c]);
        unique case (md[c])
            2'd0:
            begin
                prev = v;
                v -= n;
                if (v <= 0)
                begin
                    if (armed[c])
                    begin
                        if (prev != 0) lvl[c] = 1;
                        armed[c] = 0;
                    end
                    v += bcd[c] ? 10000 : 65536;
                end
            end
            2'd1, 2'd2:
            begin
                if (r < 1) r = 1;
                v -= n;
                if (v <= 0) v += ((-v) / r + 1) * r;
            end
            default:
            begin
                if (r < 2) r = 2;
                v -= 2 * n;
                while (v <= 0)
                begin
                    lvl[c] ^= 1'b1;
                    v += r;
                    if (r & 1) v -= lvl[c] ? 1 : 3;
                end
            end
        endcase
        cnt[c] = v & 17'h1ffff;
    endtask

    task automatic ctrl_word_model(bit [7:0] w);
        int c;
        c = w[7:6];
        if (c >= NC) return;
        clock_counter(c, 1);
        if (w[5:4] == 0)
        begin
            lat[c] = cnt[c];
            lat_held[c] = 1;
            return;
        end
        bcd[c] = w[0];
        md[c] = w[2:1];
        lvl[c] = (w[2:1] != 0);
        if (w[2:1] <= 1) armed[c] = 1;
        phase[c] = 1;
        ld_pend[c] = 0;
        acc[c] = w[5:4];
        tog[c] = 0;
    endtask

    task automatic load_byte(int c, bit [7:0] w);
        int unsigned ld;
        bit done;
        ld = 0;
        done = 0;
        unique case (acc[c])
            2'd1:
            begin
                ld = w;
                done = 1;
            end
            2'd2:
            begin
                ld = w << 8;
                cnt[c] = ld;
                done = 1;
            end
            2'd3:
            begin
                if (!tog[c])
                begin
                    lo_hold[c] = w;
                    tog[c] = 1;
                end
                else
                begin
                    tog[c] = 0;
                    ld = (w << 8) | lo_hold[c];
                    done = 1;
                end
            end
            default:
            begin
            end
        endcase
        if (!done) return;
        ld_pend[c] = 1;
        if (bcd[c]) ld = from_bcd(ld);
        if (md[c] == 1)
            ld = (ld == 0) ? (bcd[c] ? 10000 : 32'h10000) : ld + 1;
        else if (md[c] != 0 && ld == 0)
            ld = bcd[c] ? 10000 : 32'h10000;
        rld[c] = ld;
    endtask

    function automatic bit [7:0] read_byte(int c);
        int unsigned v;
        v = lat_held[c] ? lat[c] : cnt[c];
        if (acc[c] == 0) return 8'h00;
        if (bcd[c]) v = to_bcd(v);
        unique case (acc[c])
            2'd1:
            begin
                lat_held[c] = 0;
                return v[7:0];
            end
            2'd2:
            begin
                lat_held[c] = 0;
                return v[15:8];
            end
            default:
            begin
                if (!tog[c])
                begin
                    tog[c] = 1;
                    return v[7:0];
                end
                tog[c] = 0;
                lat_held[c] = 0;
                return v[15:8];
            end
        endcase
    endfunction

    task automatic predict_transfer(bit [1:0] k, bit [1:0] a, bit [7:0] wd, bit [4:0] tc);
        timer_result_t res;
        int n;
        res = '0;
        if (k == tcit_pkg::KIND_WRITE)
        begin
            if (a == tcit_pkg::ADDR_CTRL) ctrl_word_model(wd);
            else if (a < NC) load_byte(a, wd);
        end
        else if (k == tcit_pkg::KIND_READ)
        begin
            if (a < 3 && a < NC) res.rd = read_byte(a);
        end
        else if (k == tcit_pkg::KIND_TICK && tc != 0)
        begin
            n = (tc > tcit_pkg::MAX_TICKS_DEF) ? tcit_pkg::MAX_TICKS_DEF : tc;
            for (int c = 0; c < NC; c++) clock_counter(c, n);
        end
        for (int c = 0; c < 3; c++) res.outs[c] = (c < NC) ? lvl[c] : 1'b0;
        result_q.push_back(res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                cnt[c] = 0; rld[c] = 0; lat[c] = 0; lat_held[c] = 0; tog[c] = 0;
                acc[c] = 0; md[c] = 0; bcd[c] = 0; lvl[c] = 0; armed[c] = 0;
                ld_pend[c] = 0; phase[c] = 0; lo_hold[c] = 0;
            end
            result_q.delete();
            fail_count = 0;
            transfers = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("unexpected result", read_data, 0);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (read_data !== want.rd) report_mismatch("read_data", read_data, want.rd);
                    if (out_zero !== want.outs[0])
                        report_mismatch("out_zero", out_zero, want.outs[0]);
                    if (out_one !== want.outs[1])
                        report_mismatch("out_one", out_one, want.outs[1]);
                    if (out_two !== want.outs[2])
                        report_mismatch("out_two", out_two, want.outs[2]);
                end
                transfers++;
            end
            if (item_valid && item_ready)
            begin
                predict_transfer(kind, addr, write_data, tick_count);
                transfers++;
            end
        end
        pending = result_q.size();
    end

endmodule

// ----- bench/three_channel_interval_timer_unit_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the interval timer; checking lives in timer_checker.
module three_channel_interval_timer_unit_tb;

    localparam int STALL_LIMIT = 20000;   // cycles without any transfer
    localparam int RANDOM_ITEMS = 1750;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [1:0] kind;
    logic [1:0] addr;
    logic [7:0] write_data;
    logic [4:0] tick_count;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] read_data;
    logic       out_zero;
    logic       out_one;
    logic       out_two;

    int fail_count;
    int pending;
    int transfers;

    // idle percentages for sender and receiver, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    int sent_items;

    three_channel_interval_timer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .addr         (addr),
        .write_data   (write_data),
        .tick_count   (tick_count),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .out_zero     (out_zero),
        .out_one      (out_one),
        .out_two      (out_two)
    );

    timer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .addr         (addr),
        .write_data   (write_data),
        .tick_count   (tick_count),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .out_zero     (out_zero),
        .out_one      (out_one),
        .out_two      (out_two),
        .fail_count   (fail_count),
        .pending      (pending),
        .transfers    (transfers)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: ready toggles at the falling edge, idling at the phase rate.
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any transfer clears the count.
    initial
    begin
        int idle_cycles;
        int last_transfers;
        idle_cycles = 0;
        last_transfers = 0;
        forever
        begin
            @(posedge clk);
            if (transfers != last_transfers)
            begin
                idle_cycles = 0;
                last_transfers = transfers;
            end
            else if (++idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // One transfer on the item channel; random gaps before it per idle rate.
    task automatic send_item(bit [1:0] k, bit [1:0] a, bit [7:0] wd, bit [4:0] tc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        addr <= a;
        write_data <= wd;
        tick_count <= tc;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        sent_items++;
    endtask

    task automatic go_quiet();
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Program one counter: control word, then reload bytes in the chosen order.
    task automatic program_counter(bit [1:0] c, bit [1:0] order, bit [1:0] mode,
                                   bit bcd, bit [15:0] reload);
        send_item(tcit_pkg::KIND_WRITE, tcit_pkg::ADDR_CTRL, {c, order, 1'b0, mode, bcd}, 5'd0);
        if (order == 2'd2) send_item(tcit_pkg::KIND_WRITE, c, reload[15:8], 5'd0);
        else send_item(tcit_pkg::KIND_WRITE, c, reload[7:0], 5'd0);
        if (order == 2'd3) send_item(tcit_pkg::KIND_WRITE, c, reload[15:8], 5'd0);
    endtask

    // Mostly well-formed sequences: program, tick, latch and read back.
    task automatic random_item();
        int pick;
        bit [1:0] c;
        bit [15:0] rv;
        pick = $urandom_range(99);
        c = $urandom_range(2);
        // small reloads dominate so terminal counts and toggles occur often
        rv = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        if (pick < 12)
            program_counter(c, 2'($urandom_range(3, 1)), 2'($urandom), 1'($urandom), rv);
        else if (pick < 50)
            send_item(tcit_pkg::KIND_TICK, 2'($urandom), 8'($urandom),
                      5'($urandom_range(16, 1)));
        else if (pick < 58)
            send_item(tcit_pkg::KIND_WRITE, tcit_pkg::ADDR_CTRL, {c, 2'b00, 4'($urandom)},
                      5'($urandom));
        else if (pick < 80)
            send_item(tcit_pkg::KIND_READ, 2'($urandom), 8'($urandom), 5'($urandom));
        else if (pick < 90)
            send_item(tcit_pkg::KIND_WRITE, 2'($urandom), 8'($urandom), 5'($urandom));
        else
            // noise: unknown kind, out-of-range ticks, odd control words
            send_item(2'($urandom), 2'($urandom), 8'($urandom), 5'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        kind = tcit_pkg::KIND_WRITE;
        addr = 2'd0;
        write_data = 8'd0;
        tick_count = 5'd0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent_items = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reads/writes before any access order, control read,
        // unused counter, unknown kind, tick extremes.
        send_item(tcit_pkg::KIND_READ, 2'd0, 8'h00, 5'd0);
        send_item(tcit_pkg::KIND_WRITE, 2'd1, 8'hff, 5'd0);
        send_item(tcit_pkg::KIND_READ, tcit_pkg::ADDR_CTRL, 8'h00, 5'd0);
        send_item(tcit_pkg::KIND_WRITE, tcit_pkg::ADDR_CTRL, 8'hf6, 5'd0);
        send_item(2'd3, 2'd2, 8'h55, 5'd31);
        // every mode, including a mode-3 reload of one and BCD digits above 9
        program_counter(2'd0, 2'd3, 2'd0, 1'b0, 16'h0005);
        program_counter(2'd1, 2'd1, 2'd1, 1'b0, 16'h0000);
        program_counter(2'd2, 2'd3, 2'd3, 1'b0, 16'h0001);
        send_item(tcit_pkg::KIND_TICK, 2'd0, 8'h00, 5'd0);
        send_item(tcit_pkg::KIND_TICK, 2'd0, 8'h00, 5'd16);
        send_item(tcit_pkg::KIND_TICK, 2'd0, 8'h00, 5'd31);
        program_counter(2'd1, 2'd2, 2'd2, 1'b1, 16'hff00);
        program_counter(2'd2, 2'd3, 2'd3, 1'b1, 16'h9999);
        send_item(tcit_pkg::KIND_TICK, 2'd0, 8'h00, 5'd1);
        send_item(tcit_pkg::KIND_WRITE, tcit_pkg::ADDR_CTRL, 8'h80, 5'd0);   // latch counter 2
        send_item(tcit_pkg::KIND_READ, 2'd2, 8'h00, 5'd0);
        send_item(tcit_pkg::KIND_READ, 2'd2, 8'h00, 5'd0);
        send_item(tcit_pkg::KIND_READ, 2'd1, 8'h00, 5'd0);

        // Sender stalls until every result has drained.
        go_quiet();

        send_idle_pct = 22;
        recv_idle_pct = 61;
        while (sent_items < RANDOM_ITEMS / 3) random_item();
        send_idle_pct = 61;
        recv_idle_pct = 22;
        while (sent_items < 2 * (RANDOM_ITEMS / 3)) random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_items < RANDOM_ITEMS) random_item();

        go_quiet();
        repeat (300) @(posedge clk);

        $display("covered %0d transfers: all modes, BCD, latch and two-byte access,",
                 sent_items);
        $display("unused counters and odd kinds, under three idle mixes");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/tcit_pkg.sv
src/tcit_ctrl.sv
src/tcit_dp.sv
src/three_channel_interval_timer_unit.sv
bench/timer_checker.sv
bench/three_channel_interval_timer_unit_tb.sv
